[hdl/crfe_pkg.sv]
// Shared constants, codes and control types of the clipped rectangle fill engine.
package crfe_pkg;

	localparam int PANEL_WIDTH_DEF  = 320;
	localparam int PANEL_HEIGHT_DEF = 240;
	localparam int COORD_W          = 16;
	localparam int COLOR_W          = 16;
	localparam int CNT_W            = 32;
	localparam int CMD_W            = 3;
	localparam int OUTLINE_FILLS    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL_RECT   = 3'd0,
		CMD_FILL_SCREEN = 3'd1,
		CMD_OUTLINE     = 3'd2,
		CMD_READ_PIXEL  = 3'd3,
		CMD_CLEAR_COUNT = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_ADDR,
		ST_WALK,
		ST_READ,
		ST_DONE
	} state_t;

	// sequencer -> raster walker
	typedef struct packed {
		logic load;
		logic step;
	} raster_ctl_t;

	// raster walker -> sequencer
	typedef struct packed {
		logic last_col;
		logic last_row;
	} raster_sts_t;

endpackage

[hdl/crfe_frame_store.sv]
// Frame store: one write port and one registered read port.
module crfe_frame_store import crfe_pkg::*; #(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [COLOR_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/crfe_raster.sv]
// Raster walker: column/row counters and store address for the clipped area.
module crfe_raster import crfe_pkg::*; #(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int XW    = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1,
	localparam int YW    = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1
) (
	input  logic          clk,
	input  raster_ctl_t   ctl,
	input  logic [XW-1:0] xs,
	input  logic [XW-1:0] xe,
	input  logic [YW-1:0] ys,
	input  logic [YW-1:0] ye,
	output logic [AW-1:0] addr,
	output raster_sts_t   sts
);

	localparam logic [AW-1:0] ROW_STEP = AW'(PANEL_WIDTH);

	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [AW-1:0] row_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] row_base;
	logic [AW-1:0] row_next;

	assign row_base = AW'(ys) * ROW_STEP;
	assign row_next = row_q + ROW_STEP;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q    <= xs;
			y_q    <= ys;
			row_q  <= row_base;
			addr_q <= row_base + AW'(xs);
		end else if (ctl.step) begin
			if (sts.last_col) begin
				// wrap to the start of the next row
				x_q    <= xs;
				y_q    <= y_q + YW'(1);
				row_q  <= row_next;
				addr_q <= row_next + AW'(xs);
			end else begin
				x_q    <= x_q + XW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	assign sts.last_col = (x_q == xe);
	assign sts.last_row = (y_q == ye);
	assign addr         = addr_q;

endmodule

[hdl/clipped_rect_fill_engine_core.sv]
// Top level of the clipped rectangle fill engine: command sequencer, clipper and counters.
// After reset the frame store is cleared, one pixel a cycle, all PANEL_WIDTH*PANEL_HEIGHT
// pixels (76800 by default); busy stays high and no command is taken until it ends.
// A command runs alone, busy high, and ends in a one-cycle done strobe the receiver cannot
// stall. A primitive passes SETUP and ADDR, then writes its clipped area, one store write a
// cycle; a rejected primitive is skipped in SETUP. Rectangle and screen fill are one
// primitive, outline its four in turn; a read passes SETUP, ADDR and READ, an off-panel read
// ends from SETUP; fill count clear and unused codes go from IDLE straight to DONE.
module clipped_rect_fill_engine_core import crfe_pkg::*; #(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [COORD_W-1:0] left,
	input  logic signed [COORD_W-1:0] top,
	input  logic signed [COORD_W-1:0] right,
	input  logic signed [COORD_W-1:0] bottom,
	input  logic [COLOR_W-1:0]        color,
	output logic                      done,
	output logic [COLOR_W-1:0]        pixel_value,
	output logic [CNT_W-1:0]          fill_total,
	output logic [CNT_W-1:0]          offpanel_total
);

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
	localparam int YW    = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
	localparam int EW    = COORD_W + 1;

	localparam logic signed [EW-1:0]      W_S    = EW'(PANEL_WIDTH);
	localparam logic signed [EW-1:0]      H_S    = EW'(PANEL_HEIGHT);
	localparam logic signed [COORD_W-1:0] W_LAST = COORD_W'(PANEL_WIDTH - 1);
	localparam logic signed [COORD_W-1:0] H_LAST = COORD_W'(PANEL_HEIGHT - 1);
	localparam logic [XW-1:0]             X_MAX  = XW'(PANEL_WIDTH - 1);
	localparam logic [YW-1:0]             Y_MAX  = YW'(PANEL_HEIGHT - 1);
	localparam logic [AW-1:0]             A_LAST = AW'(DEPTH - 1);
	localparam logic [1:0]                LAST_PRIM = 2'(OUTLINE_FILLS - 1);

	state_t state_q, state_d;

	// latched command
	cmd_t                      cmd_q;
	logic signed [COORD_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [COLOR_W-1:0]        color_q;
	logic [1:0]                prim_q;       // outline edge in progress

	// clipped bounds of the current primitive
	logic [XW-1:0] xs_q, xe_q;
	logic [YW-1:0] ys_q, ye_q;
	logic          inpanel_q;

	logic [CNT_W-1:0] fill_cnt_q;
	logic [CNT_W-1:0] off_cnt_q;
	logic [AW-1:0]    clr_addr_q;

	// clipper
	logic signed [COORD_W-1:0] x1, y1, x2, y2;
	logic signed [EW-1:0]      x1e, y1e, x2e, y2e;
	logic                      reject, partial;
	logic [XW-1:0]             xs_d, xe_d;
	logic [YW-1:0]             ys_d, ye_d;

	logic        accept, is_read, more_prims, area_end, prim_adv;
	raster_ctl_t rctl;
	raster_sts_t rsts;
	logic [AW-1:0]      raster_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic [COLOR_W-1:0] mem_rdata;

	assign accept     = start && (state_q == ST_IDLE);
	assign is_read    = (cmd_q == CMD_READ_PIXEL);
	assign more_prims = (cmd_q == CMD_OUTLINE) && (prim_q != LAST_PRIM);
	assign area_end   = rsts.last_col && rsts.last_row;

	// Corners of the current primitive. A read is clipped as a single point, so that
	// "not rejected" is exactly "inside the panel".
	always_comb begin
		x1 = left_q;
		y1 = top_q;
		x2 = right_q;
		y2 = bottom_q;
		unique case (cmd_q)
			CMD_FILL_SCREEN: begin
				x1 = '0;
				y1 = '0;
				x2 = W_LAST;
				y2 = H_LAST;
			end
			CMD_OUTLINE: begin
				unique case (prim_q)
					2'd0: y2 = top_q;     // top row
					2'd1: y1 = bottom_q;  // bottom row
					2'd2: x2 = left_q;    // left column
					default: x1 = right_q; // right column
				endcase
			end
			CMD_READ_PIXEL: begin
				x2 = left_q;
				y2 = top_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		x1e = EW'(x1);
		y1e = EW'(y1);
		x2e = EW'(x2);
		y2e = EW'(y2);
		reject  = (x1e > x2e) || (y1e > y2e) || x2e[EW-1] || y2e[EW-1] ||
		          (x1e >= W_S) || (y1e >= H_S);
		partial = x1e[EW-1] || y1e[EW-1] || (x2e >= W_S) || (y2e >= H_S);
		xs_d = x1e[EW-1]   ? '0    : x1[XW-1:0];
		ys_d = y1e[EW-1]   ? '0    : y1[YW-1:0];
		xe_d = (x2e >= W_S) ? X_MAX : x2[XW-1:0];
		ye_d = (y2e >= H_S) ? Y_MAX : y2[YW-1:0];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		rctl      = '0;
		prim_adv  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = raster_addr;
		mem_wdata = color_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == A_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					priority case (cmd_t'(command))
						CMD_FILL_RECT, CMD_FILL_SCREEN, CMD_OUTLINE, CMD_READ_PIXEL:
							state_d = ST_SETUP;
						default:
							state_d = ST_DONE;
					endcase
				end
			end
			ST_SETUP: begin
				if (!reject) begin
					state_d = ST_ADDR;
				end else if (more_prims) begin
					prim_adv = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ADDR: begin
				rctl.load = 1'b1;
				state_d   = is_read ? ST_READ : ST_WALK;
			end
			ST_WALK: begin
				mem_we    = 1'b1;
				rctl.step = 1'b1;
				if (area_end) begin
					if (more_prims) begin
						prim_adv = 1'b1;
						state_d  = ST_SETUP;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers: counters, clear sweep, outline edge index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			off_cnt_q  <= '0;
			clr_addr_q <= '0;
			prim_q     <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (accept) begin
				prim_q <= '0;
				priority case (cmd_t'(command))
					CMD_FILL_RECT, CMD_FILL_SCREEN:
						fill_cnt_q <= fill_cnt_q + CNT_W'(1);
					CMD_OUTLINE:
						fill_cnt_q <= fill_cnt_q + CNT_W'(OUTLINE_FILLS);
					CMD_CLEAR_COUNT:
						fill_cnt_q <= '0;
					default: begin
					end
				endcase
			end else if (prim_adv) begin
				prim_q <= prim_q + 2'd1;
			end
			if ((state_q == ST_SETUP) && !is_read && (reject || partial)) begin
				off_cnt_q <= off_cnt_q + CNT_W'(1);
			end
		end
	end

	// command and clip payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(command);
			left_q   <= left;
			top_q    <= top;
			right_q  <= right;
			bottom_q <= bottom;
			color_q  <= color;
		end
		if (state_q == ST_SETUP) begin
			xs_q      <= xs_d;
			xe_q      <= xe_d;
			ys_q      <= ys_d;
			ye_q      <= ye_d;
			inpanel_q <= !reject;
		end
	end

	crfe_raster #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_raster (
		.clk  (clk),
		.ctl  (rctl),
		.xs   (xs_q),
		.xe   (xe_q),
		.ys   (ys_q),
		.ye   (ye_q),
		.addr (raster_addr),
		.sts  (rsts)
	);

	crfe_frame_store #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_READ),
		.raddr (raster_addr),
		.rdata (mem_rdata)
	);

	// result transfer: counters already hold their post-command values in the strobe cycle
	assign busy           = (state_q != ST_IDLE);
	assign done           = (state_q == ST_DONE);
	assign pixel_value    = (is_read && inpanel_q) ? mem_rdata : '0;
	assign fill_total     = fill_cnt_q;
	assign offpanel_total = off_cnt_q;

endmodule
